>>> rtl/core/assert_macros.svh
// Assertion macros shared by the turret controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/slt_pkg.sv
// Shared types, constants and the servo pulse map of the turret controller.
package slt_pkg;

	// Register indexes on the configuration port
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_PAN_STEP     = 3'd0;
	localparam logic [IDX_W-1:0] REG_PAN_LIMIT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_TILT_STEP    = 3'd2;
	localparam logic [IDX_W-1:0] REG_TILT_FLOOR   = 3'd3;
	localparam logic [IDX_W-1:0] REG_TILT_CEILING = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOCK_LIMIT   = 3'd5;
	localparam int CFG_W = 15;

	// Register reset values
	localparam logic [5:0]  PAN_STEP_RST     = 6'd2;
	localparam logic [7:0]  PAN_LIMIT_RST    = 8'd180;
	localparam logic [5:0]  TILT_STEP_RST    = 6'd1;
	localparam logic [7:0]  TILT_FLOOR_RST   = 8'd90;
	localparam logic [7:0]  TILT_CEILING_RST = 8'd130;
	localparam logic [14:0] LOCK_LIMIT_RST   = 15'd1740;

	// Angle constants
	localparam logic [7:0] ANGLE_MAX  = 8'd180;
	localparam logic [7:0] PAN_RESET  = 8'd0;
	localparam logic [7:0] TILT_RESET = 8'd90;

	// Echo validity window (2..400 cm) and conversion
	localparam logic [14:0] ECHO_MIN_US = 15'd117;
	localparam logic [14:0] ECHO_MAX_US = 15'd23199;
	localparam int          US_PER_CM   = 58;
	localparam int          QUO_W       = 9;
	localparam logic [QUO_W-1:0] DIST_MAX = 9'd400;

	// Stream widths
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 56;

	// Pulse map: 500 + floor(angle*100/9) = 500 + (angle*5825500) >> 19, exact for 0..180
	localparam logic [22:0] PULSE_MUL  = 23'd5825500;
	localparam logic [11:0] PULSE_BASE = 12'd500;

	// Per-axis sweep control
	typedef struct packed {
		logic step_en;  // advance one sweep tick
		logic load_en;  // jump to held angle
	} axis_ctl_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [11:0] pulse_of(input logic [7:0] angle);
		logic [30:0] prod;
		prod = 31'(angle) * 31'(PULSE_MUL);
		return prod[30:19] + PULSE_BASE;
	endfunction

endpackage

>>> rtl/core/scan_and_lock_turret_controller_top.sv
// Top level of the scan-and-lock turret controller: ring, lock, sequencer, output.
//
//  channel  | dir | handshake          | content
//  s_*      | in  | s_tvalid/s_tready  | sweep tick or echo sample, one per beat
//  m_*      | out | m_tvalid/m_tready  | angles, pulses, lock, distance, one per input beat
//  cfg_*    | in  | cfg_we             | register writes, index 0..5
//
// A sweep tick goes from the ring state straight to the output stage; a sample passes
// ring update, lock compare, the bit-serial divider (9 steps and a done strobe, skipped
// with an empty ring), then the output stage.
// One item at a time; s_tready is high only when the sequencer is idle, and the
// next beat is taken while a finished result still waits in the output register.
// A stalled m_tready holds the sequencer in its output state while an earlier result waits.
// Reset (arst_n low) clears the echo ring, sweep state and registers at once.
`include "assert_macros.svh"

module scan_and_lock_turret_controller_top #(
	parameter int RING_DEPTH = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [slt_pkg::S_DATA_W-1:0] s_tdata,   // echo_us[14:0], echo_seen[15]
	input  logic                         s_tuser,   // action: 0 tick, 1 sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// pan_angle[7:0], tilt_angle[15:8], pan_pulse_us[27:16], tilt_pulse_us[39:28],
	// locked[40], distance_cm[49:41], sample_taken[50], zero[55:51]
	output logic [slt_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         cfg_we,
	input  logic [slt_pkg::IDX_W-1:0]    cfg_index,
	input  logic [slt_pkg::CFG_W-1:0]    cfg_data
);

	localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = 15 + $clog2(RING_DEPTH);
	localparam int DEN_W  = CNT_W + 6;
	localparam int LOCK_W = 15 + CNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RING = 3'd1;
	localparam logic [2:0] ST_LOCK = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	// Configuration registers
	logic [5:0]  pan_step_q;
	logic [7:0]  pan_limit_q;
	logic [5:0]  tilt_step_q;
	logic [7:0]  tilt_floor_q;
	logic [7:0]  tilt_ceiling_q;
	logic [14:0] lock_limit_q;

	// Sequencer and item
	logic [2:0]  state_q;
	logic        action_q;
	logic [14:0] echo_q;
	logic        seen_q;
	logic        taken_q;

	// Ring and filter state
	logic [14:0]      ring_q [RING_DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic             hold_q;
	logic [7:0]       held_pan_q;
	logic [7:0]       held_tilt_q;
	logic [slt_pkg::QUO_W-1:0] cm_q;

	// Output register
	logic                         m_tvalid_q;
	logic [slt_pkg::M_DATA_W-1:0] m_tdata_q;

	logic                      s_accept;
	logic                      echo_ok;
	logic [14:0]               old_echo;
	logic [LOCK_W-1:0]         lock_bound;
	logic                      lock_now;
	logic                      out_free;
	logic                      div_start;
	logic [DEN_W-1:0]          div_den;
	slt_pkg::div_stat_t        div_stat;
	logic [slt_pkg::QUO_W-1:0] div_quo;
	slt_pkg::axis_ctl_t        axis_ctl;
	logic [7:0]                pan_angle;
	logic [7:0]                tilt_angle;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Configuration writes; unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_step_q     <= slt_pkg::PAN_STEP_RST;
			pan_limit_q    <= slt_pkg::PAN_LIMIT_RST;
			tilt_step_q    <= slt_pkg::TILT_STEP_RST;
			tilt_floor_q   <= slt_pkg::TILT_FLOOR_RST;
			tilt_ceiling_q <= slt_pkg::TILT_CEILING_RST;
			lock_limit_q   <= slt_pkg::LOCK_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slt_pkg::REG_PAN_STEP:     pan_step_q     <= cfg_data[5:0];
				slt_pkg::REG_PAN_LIMIT:    pan_limit_q    <= cfg_data[7:0];
				slt_pkg::REG_TILT_STEP:    tilt_step_q    <= cfg_data[5:0];
				slt_pkg::REG_TILT_FLOOR:   tilt_floor_q   <= cfg_data[7:0];
				slt_pkg::REG_TILT_CEILING: tilt_ceiling_q <= cfg_data[7:0];
				slt_pkg::REG_LOCK_LIMIT:   lock_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample validity and the ring entry about to be replaced
	assign echo_ok  = seen_q && (echo_q >= slt_pkg::ECHO_MIN_US)
		&& (echo_q <= slt_pkg::ECHO_MAX_US);
	assign old_echo = ring_q[slot_q];

	// Lock: average at or below limit, compared as sum <= limit*count
	assign lock_bound = LOCK_W'(lock_limit_q) * LOCK_W'(count_q);
	assign lock_now   = (count_q != '0) && (LOCK_W'(sum_q) <= lock_bound);

	// Divisor is 58 * count; the divider runs whenever the ring holds an echo
	assign div_den   = DEN_W'(count_q) * DEN_W'(slt_pkg::US_PER_CM);
	assign div_start = (state_q == ST_LOCK) && (count_q != '0);

	// Axis control: ticks move or hold, only in the ring state
	assign axis_ctl.step_en = (state_q == ST_RING) && !action_q && !hold_q;
	assign axis_ctl.load_en = (state_q == ST_RING) && !action_q && hold_q;

	slt_axis #(
		.RESET_ANGLE(slt_pkg::PAN_RESET)
	) u_pan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (axis_ctl),
		.step      (pan_step_q),
		.lo_bound  (8'd0),
		.hi_bound  (pan_limit_q),
		.load_angle(held_pan_q),
		.angle     (pan_angle)
	);

	slt_axis #(
		.RESET_ANGLE(slt_pkg::TILT_RESET)
	) u_tilt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (axis_ctl),
		.step      (tilt_step_q),
		.lo_bound  (tilt_floor_q),
		.hi_bound  (tilt_ceiling_q),
		.load_angle(held_tilt_q),
		.angle     (tilt_angle)
	);

	slt_div #(
		.NUM_W(SUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_q),
		.den   (div_den),
		.stat  (div_stat),
		.quo   (div_quo)
	);

	// Input item capture
	always_ff @(posedge clk) begin
		if (s_accept) begin
			action_q <= s_tuser;
			echo_q   <= s_tdata[14:0];
			seen_q   <= s_tdata[15];
		end
	end

	// Sequencer, ring, lock and distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
			slot_q      <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			hold_q      <= 1'b0;
			held_pan_q  <= slt_pkg::PAN_RESET;
			held_tilt_q <= slt_pkg::TILT_RESET;
			cm_q        <= '0;
			taken_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept) state_q <= ST_RING;
				end
				ST_RING: begin
					taken_q <= action_q && echo_ok;
					if (!action_q) begin
						state_q <= ST_EMIT;
					end else begin
						if (echo_ok) begin
							ring_q[slot_q] <= echo_q;
							sum_q   <= sum_q - SUM_W'(old_echo) + SUM_W'(echo_q);
							if (old_echo == '0) count_q <= count_q + CNT_W'(1);
							slot_q  <= (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0
								: slot_q + SLOT_W'(1);
						end
						state_q <= ST_LOCK;
					end
				end
				ST_LOCK: begin
					// Entering lock captures the current angles
					if (lock_now && !hold_q) begin
						held_pan_q  <= pan_angle;
						held_tilt_q <= tilt_angle;
					end
					hold_q <= lock_now;
					if (count_q != '0) begin
						state_q <= ST_DIV;
					end else begin
						cm_q    <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						cm_q    <= div_quo;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result valid: set when a beat is loaded, cleared when it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result beat, pulse map applied on the way into the output register
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			m_tdata_q <= {5'b00000, taken_q, cm_q, hold_q,
				slt_pkg::pulse_of(tilt_angle), slt_pkg::pulse_of(pan_angle),
				tilt_angle, pan_angle};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CNT_W'(RING_DEPTH), "ring count above depth")
	`ASSERT_ALWAYS(a_sum_count, clk, arst_n, (count_q == '0) == (sum_q == '0), "echo sum and count disagree")
	`ASSERT_IMPLIES(a_hold_echo, clk, arst_n, hold_q, count_q != '0, "locked with empty ring")
	`ASSERT_IMPLIES(a_div_range, clk, arst_n, div_stat.done, div_quo <= slt_pkg::DIST_MAX, "distance above 400 cm")

endmodule

>>> rtl/core/slt_axis.sv
// One servo axis: bouncing sweep between two bounds, or load of a held angle.
module slt_axis #(
	parameter logic [7:0] RESET_ANGLE = 8'd0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slt_pkg::axis_ctl_t   ctl,
	input  logic [5:0]           step,
	input  logic [7:0]           lo_bound,
	input  logic [7:0]           hi_bound,
	input  logic [7:0]           load_angle,
	output logic [7:0]           angle
);

	logic [7:0]        angle_q;
	logic              rising_q;
	logic [7:0]        lo_cap;
	logic [7:0]        hi_cap;
	logic signed [9:0] moved;
	logic              at_hi;
	logic              at_lo;

	// Bounds above full travel are clamped
	assign lo_cap = (lo_bound > slt_pkg::ANGLE_MAX) ? slt_pkg::ANGLE_MAX : lo_bound;
	assign hi_cap = (hi_bound > slt_pkg::ANGLE_MAX) ? slt_pkg::ANGLE_MAX : hi_bound;

	// Step in the current direction, then test upper bound before lower
	assign moved = rising_q ? ($signed({2'b00, angle_q}) + $signed({4'b0000, step}))
		: ($signed({2'b00, angle_q}) - $signed({4'b0000, step}));
	assign at_hi = moved >= $signed({2'b00, hi_cap});
	assign at_lo = moved <= $signed({2'b00, lo_cap});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= RESET_ANGLE;
			rising_q <= 1'b1;
		end else if (ctl.load_en) begin
			angle_q <= load_angle;
		end else if (ctl.step_en) begin
			if (at_hi) begin
				angle_q  <= hi_cap;
				rising_q <= 1'b0;
			end else if (at_lo) begin
				angle_q  <= lo_cap;
				rising_q <= 1'b1;
			end else begin
				angle_q <= moved[7:0];
			end
		end
	end

	assign angle = angle_q;

endmodule

>>> rtl/core/slt_div.sv
// Restoring divider, one quotient bit per cycle through a shared compare/subtract.
module slt_div #(
	parameter int NUM_W = 18,
	parameter int DEN_W = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUM_W-1:0]          num,
	input  logic [DEN_W-1:0]          den,
	output slt_pkg::div_stat_t        stat,
	output logic [slt_pkg::QUO_W-1:0] quo
);

	localparam int WW    = NUM_W + DEN_W;
	localparam int CNT_W = $clog2(slt_pkg::QUO_W + 1);

	logic [WW-1:0]             rem_q;
	logic [WW-1:0]             dsh_q;
	logic [slt_pkg::QUO_W-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic                      ge;

	// Shared compare; quotient known to fit QUO_W bits
	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(slt_pkg::QUO_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= WW'(num);
			dsh_q <= WW'(den) << (slt_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[slt_pkg::QUO_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

>>> bench/tb.sv
// Self-checking bench for the scan-and-lock turret controller top level.
`timescale 1ns / 100ps

module tb;

	// Kinds of input beat (tuser)
	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Indexes past the last register, writes there must be ignored
	localparam logic [slt_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [slt_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int ECHO_SLOTS = 5;
	localparam int HOLD_OFF_CYCLES = 300;

	// Result beat, last member in the lowest bits of m_tdata
	typedef struct packed {
		logic [4:0]  pad;
		logic        sample_taken;
		logic [8:0]  distance_cm;
		logic        locked;
		logic [11:0] tilt_pulse_us;
		logic [11:0] pan_pulse_us;
		logic [7:0]  tilt_angle;
		logic [7:0]  pan_angle;
	} aim_t;

	// Tracks the turret state and the results still owed by the block
	class turret_scoreboard;
		bit [5:0]  pan_step, tilt_step;
		bit [7:0]  pan_limit, tilt_floor, tilt_ceiling;
		bit [14:0] lock_limit_us;
		int unsigned echo_ring[ECHO_SLOTS];
		int unsigned ring_slot, echo_sum, echo_count;
		int pan_now, tilt_now, held_pan, held_tilt;
		bit pan_rising, tilt_rising, hold_flag;
		aim_t owed[$];
		int errors;

		function new();
			pan_step      = slt_pkg::PAN_STEP_RST;
			pan_limit     = slt_pkg::PAN_LIMIT_RST;
			tilt_step     = slt_pkg::TILT_STEP_RST;
			tilt_floor    = slt_pkg::TILT_FLOOR_RST;
			tilt_ceiling  = slt_pkg::TILT_CEILING_RST;
			lock_limit_us = slt_pkg::LOCK_LIMIT_RST;
			foreach (echo_ring[i]) echo_ring[i] = 0;
			ring_slot   = 0;
			echo_sum    = 0;
			echo_count  = 0;
			pan_now     = 0;
			tilt_now    = 90;
			held_pan    = 0;
			held_tilt   = 90;
			pan_rising  = 1;
			tilt_rising = 1;
			hold_flag   = 0;
			errors      = 0;
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return owed.size();
		endfunction

		function void set_reg(logic [slt_pkg::IDX_W-1:0] idx,
				logic [slt_pkg::CFG_W-1:0] val);
			case (idx)
				slt_pkg::REG_PAN_STEP:     pan_step      = val[5:0];
				slt_pkg::REG_PAN_LIMIT:    pan_limit     = val[7:0];
				slt_pkg::REG_TILT_STEP:    tilt_step     = val[5:0];
				slt_pkg::REG_TILT_FLOOR:   tilt_floor    = val[7:0];
				slt_pkg::REG_TILT_CEILING: tilt_ceiling  = val[7:0];
				slt_pkg::REG_LOCK_LIMIT:   lock_limit_us = val;
				default: ;
			endcase
		endfunction

		function int clip_angle(bit [7:0] v);
			return (v > 180) ? 180 : int'(v);
		endfunction

		function bit [11:0] servo_width(int angle);
			return 12'(500 + (angle * 2000) / 180);
		endfunction

		// Advance the turret for one accepted beat and queue its result
		function void note_input(logic act, logic [14:0] echo, logic seen);
			aim_t r;
			int pan_top, tilt_bot, tilt_top;
			bit taken, lock_now;
			taken = 0;
			if (act == ACT_TICK) begin
				if (hold_flag) begin
					pan_now  = held_pan;
					tilt_now = held_tilt;
				end else begin
					pan_top  = clip_angle(pan_limit);
					tilt_bot = clip_angle(tilt_floor);
					tilt_top = clip_angle(tilt_ceiling);
					pan_now += pan_rising ? int'(pan_step) : -int'(pan_step);
					if (pan_now >= pan_top) begin
						pan_now = pan_top;
						pan_rising = 0;
					end else if (pan_now <= 0) begin
						pan_now = 0;
						pan_rising = 1;
					end
					tilt_now += tilt_rising ? int'(tilt_step) : -int'(tilt_step);
					if (tilt_now >= tilt_top) begin
						tilt_now = tilt_top;
						tilt_rising = 0;
					end else if (tilt_now <= tilt_bot) begin
						tilt_now = tilt_bot;
						tilt_rising = 1;
					end
				end
			end else begin
				if (seen && echo >= slt_pkg::ECHO_MIN_US && echo <= slt_pkg::ECHO_MAX_US) begin
					if (echo_ring[ring_slot] != 0) begin
						echo_sum -= echo_ring[ring_slot];
						echo_count--;
					end
					echo_ring[ring_slot] = echo;
					echo_sum += echo;
					echo_count++;
					ring_slot = (ring_slot + 1) % ECHO_SLOTS;
					taken = 1;
				end
				lock_now = echo_count > 0 && echo_sum <= lock_limit_us * echo_count;
				// angles are captured only on the way into lock
				if (lock_now && !hold_flag) begin
					held_pan  = pan_now;
					held_tilt = tilt_now;
				end
				hold_flag = lock_now;
			end
			r = '0;
			r.pan_angle     = pan_now[7:0];
			r.tilt_angle    = tilt_now[7:0];
			r.pan_pulse_us  = servo_width(pan_now);
			r.tilt_pulse_us = servo_width(tilt_now);
			r.locked        = hold_flag;
			r.distance_cm   = (echo_count > 0)
				? 9'(echo_sum / (slt_pkg::US_PER_CM * echo_count)) : '0;
			r.sample_taken  = taken;
			owed.push_back(r);
		endfunction

		task compare(string field, logic [11:0] got, logic [11:0] want);
			if (got !== want)
				report($sformatf("%s got %0d, want %0d", field, got, want));
		endtask

		task check_result(logic [slt_pkg::M_DATA_W-1:0] data);
			aim_t got, want;
			if (owed.size() == 0) begin
				report($sformatf("result beat with none owed: %h", data));
				return;
			end
			got  = aim_t'(data);
			want = owed.pop_front();
			compare("pan_angle", 12'(got.pan_angle), 12'(want.pan_angle));
			compare("tilt_angle", 12'(got.tilt_angle), 12'(want.tilt_angle));
			compare("pan_pulse_us", got.pan_pulse_us, want.pan_pulse_us);
			compare("tilt_pulse_us", got.tilt_pulse_us, want.tilt_pulse_us);
			compare("locked", 12'(got.locked), 12'(want.locked));
			compare("distance_cm", 12'(got.distance_cm), 12'(want.distance_cm));
			compare("sample_taken", 12'(got.sample_taken), 12'(want.sample_taken));
			compare("pad", 12'(got.pad), 12'(want.pad));
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [slt_pkg::S_DATA_W-1:0]    s_tdata = '0;
	logic                            s_tuser = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [slt_pkg::M_DATA_W-1:0]    m_tdata;
	logic                            cfg_we = 1'b0;
	logic [slt_pkg::IDX_W-1:0]       cfg_index = '0;
	logic [slt_pkg::CFG_W-1:0]       cfg_data = '0;

	logic quiet = 1'b0;
	int   hold_asked = 0;
	int   hold_served = 0;
	int   hold_left = 0;

	turret_scoreboard sb;

	scan_and_lock_turret_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= 11);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tdata);
	end

	// Offer one beat, idling first now and then
	task automatic send(input logic act, input logic [14:0] echo, input logic seen);
		if (!quiet && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {seen, echo};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_input(act, echo, seen);
	endtask

	// Stop offering and let every owed result come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [slt_pkg::IDX_W-1:0] idx,
			input logic [slt_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(input int unsigned p_step, input int unsigned p_lim,
			input int unsigned t_step, input int unsigned t_bot,
			input int unsigned t_top, input int unsigned lock_us);
		write_reg(slt_pkg::REG_PAN_STEP, slt_pkg::CFG_W'(p_step));
		write_reg(slt_pkg::REG_PAN_LIMIT, slt_pkg::CFG_W'(p_lim));
		write_reg(slt_pkg::REG_TILT_STEP, slt_pkg::CFG_W'(t_step));
		write_reg(slt_pkg::REG_TILT_FLOOR, slt_pkg::CFG_W'(t_bot));
		write_reg(slt_pkg::REG_TILT_CEILING, slt_pkg::CFG_W'(t_top));
		write_reg(slt_pkg::REG_LOCK_LIMIT, slt_pkg::CFG_W'(lock_us));
		write_reg(REG_SPARE_LO, slt_pkg::CFG_W'($urandom));
		write_reg(REG_SPARE_HI, slt_pkg::CFG_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Half ticks; the samples are mostly valid echoes, many near lock range, the rest junk
	task automatic send_random();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			send(ACT_TICK, 15'($urandom), 1'($urandom));
		else if (pick < 70)
			send(ACT_SAMPLE, 15'($urandom_range(117, 3000)), 1'b1);
		else if (pick < 86)
			send(ACT_SAMPLE, 15'($urandom_range(117, 23199)), 1'b1);
		else if (pick < 91)
			send(ACT_SAMPLE, 15'($urandom), 1'b0);
		else if (pick < 95)
			send(ACT_SAMPLE, 15'($urandom_range(0, 116)), 1'b1);
		else
			send(ACT_SAMPLE, 15'($urandom_range(23200, 32767)), 1'b1);
	endtask

	// Run limit
	initial begin
		#1_000_000;
		$display("scan_and_lock_turret_controller_top: mismatch");
		$finish;
	end

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: sweep, echo window edges, ring wrap into lock, hold, release
		repeat (3) send(ACT_TICK, '0, 1'b0);
		send(ACT_SAMPLE, 15'd1000, 1'b0);
		send(ACT_SAMPLE, 15'd116, 1'b1);
		send(ACT_SAMPLE, 15'd117, 1'b1);
		send(ACT_SAMPLE, 15'd23199, 1'b1);
		send(ACT_SAMPLE, 15'd23200, 1'b1);
		send(ACT_SAMPLE, 15'd32767, 1'b1);
		send(ACT_SAMPLE, 15'd0, 1'b1);
		repeat (5) send(ACT_SAMPLE, 15'd200, 1'b1);
		repeat (2) send(ACT_TICK, 15'h7FFF, 1'b1);
		repeat (3) send(ACT_SAMPLE, 15'd23199, 1'b1);
		repeat (2) send(ACT_TICK, '0, 1'b0);

		// Random phases, each under its own register setting
		for (int p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: set_config(45, 180, 45, 0, 180, 23199);
				1: set_config(0, 0, 63, 255, 0, 0);
				2: set_config(63, 255, 1, 180, 180, 32767);
				default: set_config($urandom_range(0, 63), $urandom_range(0, 255),
					$urandom_range(0, 63), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 4000));
			endcase
			if (p == 3)
				hold_asked <= hold_asked + 1;
			quiet <= (p == 4);
			for (int k = 0; k < 150; k++) begin
				if (p == 6 && k == 75)
					drain();
				send_random();
			end
		end

		drain();
		if (sb.errors == 0)
			$display("scan_and_lock_turret_controller_top: match");
		else
			$display("scan_and_lock_turret_controller_top: mismatch");
		$finish;
	end

endmodule
